// ===== sv/satx_pkg.sv =====
// ----------------------------------------------------------------------------
// satx_pkg
// Shared types and constants for the sprite attribute tile expander.
// ----------------------------------------------------------------------------
package satx_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COCKTAIL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BANK     = 2'd1;
   localparam int unsigned CSR_DATA_W = 2;

   // Size field codes
   localparam logic [1:0] SIZE_ONE  = 2'd0;
   localparam logic [1:0] SIZE_TWO  = 2'd1;
   localparam logic [1:0] SIZE_FOUR = 2'd2;
   localparam logic [1:0] SIZE_NONE = 2'd3;

   // Last stack index for each tile count
   localparam logic [1:0] LAST_ONE  = 2'd0;
   localparam logic [1:0] LAST_TWO  = 2'd1;
   localparam logic [1:0] LAST_FOUR = 2'd3;

   localparam logic [9:0]  BANK_TRIGGER = 10'h108;
   localparam logic [10:0] X_OFFSET     = 11'd52;
   localparam logic [10:0] X_MIRROR     = 11'd498;
   localparam logic [9:0]  Y_BASE       = 10'd256;
   localparam logic [9:0]  Y_MIRROR     = 10'd242;
   localparam logic [9:0]  Y_TALL_TWO   = 10'd16;
   localparam logic [9:0]  Y_TALL_FOUR  = 10'd48;
   localparam logic [9:0]  CLEAR_TWO    = ~10'h010;
   localparam logic [9:0]  CLEAR_FOUR   = ~10'h030;

   // Decoded sprite entry, held while its tiles go out
   typedef struct packed {
      logic [9:0]         code;
      logic [4:0]         colour;
      logic               flip_x;
      logic               flip_y;
      logic signed [10:0] pos_x;
      logic signed [9:0]  pos_y;
      logic [1:0]         last;
   } sprite_type;

   function automatic logic [9:0] bank_mask(input logic [1:0] bank);
      logic [9:0] m;
      unique case (bank)
         2'd0: m = 10'h308;
         2'd1: m = 10'h300;
         2'd2: m = 10'h008;
         2'd3: m = 10'h000;
         default: m = 10'h000;
      endcase
      return m;
   endfunction

endpackage

// ===== sv/sprite_attribute_tile_expander_core.sv =====
// ----------------------------------------------------------------------------
// sprite_attribute_tile_expander_core
// Expands sprite entries into 16x16 tile command beats.
// ----------------------------------------------------------------------------
// Flow: an accepted entry beat is held in the sprite holding register; its
//   tiles are loaded from there into the tile output register one at a time.
// Throughput: one tile beat per cycle unless rsp_ready stalls the output; an
//   entry gives 1, 2 or 4 tile beats by its tile count (none for an empty
//   entry), and all of them pass through the single tile output register.
// Reset: synchronous, active high; clears both registers and all valid flags.
// ----------------------------------------------------------------------------
module sprite_attribute_tile_expander_core
   import satx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_attr_flags,
   input  logic [7:0]             req_y_byte,
   input  logic [7:0]             req_code_byte,
   input  logic [7:0]             req_x_byte,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [9:0]             rsp_tile_code,
   output logic [4:0]             rsp_tile_colour,
   output logic                   rsp_flip_x,
   output logic                   rsp_flip_y,
   output logic signed [10:0]     rsp_pos_x,
   output logic signed [9:0]      rsp_pos_y,
   output logic                   rsp_last_tile
);

   // Configuration
   logic       cocktail_ff, cocktail_in;
   logic [1:0] bank_ff, bank_in;

   always_comb begin
      cocktail_in = cocktail_ff;
      bank_in     = bank_ff;
      if (csr_we) begin
         if (csr_index == CSR_COCKTAIL) begin
            cocktail_in = csr_wdata[0];
         end else if (csr_index == CSR_BANK) begin
            bank_in = csr_wdata[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cocktail_ff <= 1'b0;
         bank_ff     <= 2'd0;
      end else begin
         cocktail_ff <= cocktail_in;
         bank_ff     <= bank_in;
      end
   end

   // Decode the incoming entry beat
   sprite_type dec_sprite;
   logic       dec_no_tile;

   satx_decode u_decode (
      .attr_flags (req_attr_flags),
      .y_byte     (req_y_byte),
      .code_byte  (req_code_byte),
      .x_byte     (req_x_byte),
      .cocktail   (cocktail_ff),
      .bank       (bank_ff),
      .sprite     (dec_sprite),
      .no_tile    (dec_no_tile)
   );

   // Sprite holding register and stack index
   sprite_type spr_ff, spr_in;
   logic       spr_valid_ff, spr_valid_in;
   logic [1:0] idx_ff, idx_in;

   // Tile output register
   logic               out_valid_ff, out_valid_in;
   logic [9:0]         out_code_ff, out_code_in;
   logic [4:0]         out_colour_ff, out_colour_in;
   logic               out_fx_ff, out_fx_in;
   logic               out_fy_ff, out_fy_in;
   logic signed [10:0] out_x_ff, out_x_in;
   logic signed [9:0]  out_y_ff, out_y_in;
   logic               out_last_ff, out_last_in;

   logic       out_adv;
   logic       tile_load;
   logic       spr_done;
   logic       req_take;
   logic [1:0] stack_idx;

   always_comb begin
      // The output register moves when it is empty or its beat is taken
      out_adv   = !out_valid_ff || rsp_ready;
      tile_load = spr_valid_ff && out_adv;
      spr_done  = tile_load && (idx_ff == spr_ff.last);
      req_ready = !spr_valid_ff || spr_done;
      req_take  = req_valid && req_ready;

      // Reverse the stacking order when the tile is flipped vertically
      stack_idx = idx_ff ^ (spr_ff.flip_y ? spr_ff.last : 2'd0);

      spr_in       = spr_ff;
      spr_valid_in = spr_valid_ff;
      idx_in       = idx_ff;
      priority if (req_take) begin
         spr_in       = dec_sprite;
         spr_valid_in = !dec_no_tile;  // drop entries with the unused size
         idx_in       = 2'd0;
      end else if (spr_done) begin
         spr_valid_in = 1'b0;
      end else if (tile_load) begin
         idx_in = idx_ff + 2'd1;
      end

      out_valid_in  = out_adv ? spr_valid_ff : out_valid_ff;
      out_code_in   = out_code_ff;
      out_colour_in = out_colour_ff;
      out_fx_in     = out_fx_ff;
      out_fy_in     = out_fy_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_last_in   = out_last_ff;
      if (tile_load) begin
         out_code_in   = spr_ff.code | {4'b0000, stack_idx, 4'b0000};
         out_colour_in = spr_ff.colour;
         out_fx_in     = spr_ff.flip_x;
         out_fy_in     = spr_ff.flip_y;
         out_x_in      = spr_ff.pos_x;
         out_y_in      = spr_ff.pos_y + $signed({4'b0000, idx_ff, 4'b0000});
         out_last_in   = (idx_ff == spr_ff.last);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         spr_valid_ff <= spr_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      spr_ff        <= spr_in;
      out_code_ff   <= out_code_in;
      out_colour_ff <= out_colour_in;
      out_fx_ff     <= out_fx_in;
      out_fy_ff     <= out_fy_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_tile_code   = out_code_ff;
   assign rsp_tile_colour = out_colour_ff;
   assign rsp_flip_x      = out_fx_ff;
   assign rsp_flip_y      = out_fy_ff;
   assign rsp_pos_x       = out_x_ff;
   assign rsp_pos_y       = out_y_ff;
   assign rsp_last_tile   = out_last_ff;

   // Checks
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      spr_valid_ff |-> (idx_ff <= spr_ff.last))
      else $error("stack index past last tile");

   a_last_legal: assert property (@(posedge clock) disable iff (reset)
      spr_valid_ff |-> (spr_ff.last == LAST_ONE || spr_ff.last == LAST_TWO ||
                        spr_ff.last == LAST_FOUR))
      else $error("illegal tile count held");

   a_stall_holds_idx: assert property (@(posedge clock) disable iff (reset)
      (spr_valid_ff && !out_adv) |=> ($stable(idx_ff) && spr_valid_ff))
      else $error("sprite advanced while output stalled");

   a_empty_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_take && dec_no_tile) |=> !spr_valid_ff)
      else $error("empty entry not dropped");

   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      spr_done |-> req_ready)
      else $error("input blocked on final tile");

endmodule

// ===== sv/satx_decode.sv =====
// ----------------------------------------------------------------------------
// satx_decode
// Turns one raw four-byte sprite entry into the decoded sprite record.
// ----------------------------------------------------------------------------
module satx_decode
   import satx_pkg::*;
(
   input  logic [7:0] attr_flags,
   input  logic [7:0] y_byte,
   input  logic [7:0] code_byte,
   input  logic [7:0] x_byte,
   input  logic       cocktail,
   input  logic [1:0] bank,
   output sprite_type sprite,
   output logic       no_tile
);

   logic [9:0]  code_raw;
   logic [9:0]  code_bank;
   logic [10:0] x_raw;
   logic [9:0]  y_raw;
   logic [9:0]  y_ckt;
   logic [1:0]  size;

   always_comb begin
      size      = attr_flags[4:3];
      code_raw  = {1'b0, attr_flags[5], code_byte};
      code_bank = ((code_raw & BANK_TRIGGER) == BANK_TRIGGER) ?
                  (code_raw ^ bank_mask(bank)) : code_raw;
      x_raw     = {2'b00, x_byte, attr_flags[0]} + X_OFFSET;
      y_raw     = Y_BASE - {2'b00, y_byte};
      y_ckt     = cocktail ? (Y_MIRROR - y_raw) : y_raw;

      sprite.colour = {attr_flags[5], code_byte[3], code_byte[7], attr_flags[2:1]};
      sprite.flip_x = attr_flags[7] ^ cocktail;
      sprite.flip_y = attr_flags[6] ^ cocktail;
      sprite.pos_x  = cocktail ? $signed(X_MIRROR - x_raw) : $signed(x_raw);
      no_tile       = 1'b0;

      unique case (size)
         SIZE_ONE: begin
            sprite.code  = code_bank;
            sprite.pos_y = $signed(y_ckt);
            sprite.last  = LAST_ONE;
         end
         SIZE_TWO: begin
            sprite.code  = code_bank & CLEAR_TWO;
            sprite.pos_y = $signed(cocktail ? (y_ckt - Y_TALL_TWO) : y_ckt);
            sprite.last  = LAST_TWO;
         end
         SIZE_FOUR: begin
            sprite.code  = code_bank & CLEAR_FOUR;
            sprite.pos_y = $signed(cocktail ? (y_ckt - Y_TALL_FOUR) : y_ckt);
            sprite.last  = LAST_FOUR;
         end
         default: begin
            sprite.code  = code_bank;
            sprite.pos_y = $signed(y_ckt);
            sprite.last  = LAST_ONE;
            no_tile      = 1'b1;
         end
      endcase
   end

endmodule

// ===== bench/tb_sprite_attribute_tile_expander_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sprite_attribute_tile_expander_core
// Self-checking bench for the sprite tile expander. Sprite entries go in on
// the request channel and are expanded into expected tile beats by a local
// predictor. Every tile beat that leaves the block is compared against the
// oldest expected one. Runs a directed set under two register settings, then
// random phases over six register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_sprite_attribute_tile_expander_core;
   import satx_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 48;
   localparam int DIRECTED_COUNT = 11;

   // Index that maps to no register; writes to it must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // XOR masks picked by the bank register for trigger codes
   localparam logic [9:0] HELI_MASKS [4] = '{10'h308, 10'h300, 10'h008, 10'h000};

   // Directed entries, packed as {flags, y, code, x}
   localparam logic [31:0] DIRECTED [DIRECTED_COUNT] = '{
      32'h00_00_00_00,  // everything at zero, single tile
      32'hE7_FF_FF_FF,  // single tile, every other bit high, bank trigger
      32'h08_40_10_80,  // two tiles, no yflip, stack bit set on input
      32'h48_C0_3F_7F,  // two tiles with yflip
      32'h10_20_30_10,  // four tiles, no yflip
      32'hF0_FF_FF_00,  // four tiles with both flips, bank trigger
      32'h18_55_AA_55,  // unused size: no tile beats
      32'h28_80_08_40,  // two tiles, bank trigger
      32'h21_01_08_FF,  // single tile, bank trigger, x lsb set
      32'h01_FE_08_01,  // code bit 3 alone: no trigger
      32'h20_7F_00_FE   // code bit 8 alone: no trigger
   };

   typedef struct packed {
      logic [9:0]  code;
      logic [4:0]  colour;
      logic        flip_x;
      logic        flip_y;
      logic [10:0] pos_x;
      logic [9:0]  pos_y;
      logic        last;
   } tile_t;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts tile beats per entry and checks the actual ones
   // -------------------------------------------------------------------------
   class tile_scoreboard;
      tile_t expected_tiles[$];
      int errors;
      logic cocktail;
      logic [1:0] bank;

      function new();
         errors = 0;
         cocktail = 1'b0;
         bank = 2'd0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_COCKTAIL)
            cocktail = value[0];
         else if (index == CSR_BANK)
            bank = value;
      endfunction

      function int pending();
         return expected_tiles.size();
      endfunction

      function void expand_entry(logic [7:0] flags, logic [7:0] yb, logic [7:0] cb,
                                 logic [7:0] xb);
         logic [9:0] code;
         logic [4:0] colour;
         logic fx;
         logic fy;
         logic [1:0] idx_flip;
         logic [1:0] idx;
         int px;
         int py;
         int row_y;
         int count;
         tile_t t;
         py = 256 - int'(yb);
         px = 2 * int'(xb) + int'(flags[0]) + 52;
         code = {1'b0, flags[5], cb};
         fx = flags[7];
         fy = flags[6];
         // Colour is taken from the code before the bank XOR
         colour = {code[8], code[3], code[7], flags[2:1]};
         if (code[8] && code[3])
            code = code ^ HELI_MASKS[bank];
         if (cocktail) begin
            px = 498 - px;
            py = 242 - py;
            fx = ~fx;
            fy = ~fy;
         end
         idx_flip = 2'd0;
         case (flags[4:3])
            SIZE_ONE: begin
               count = 1;
            end
            SIZE_TWO: begin
               count = 2;
               if (cocktail)
                  py = py - 16;
               code = code & ~10'h010;
               idx_flip = fy ? 2'd1 : 2'd0;
            end
            SIZE_FOUR: begin
               count = 4;
               if (cocktail)
                  py = py - 48;
               code = code & ~10'h030;
               idx_flip = fy ? 2'd3 : 2'd0;
            end
            default: begin
               count = 0;
            end
         endcase
         for (int j = 0; j < count; j++) begin
            idx = 2'(j) ^ idx_flip;
            row_y = py + 16 * j;
            t.code = code | {4'b0000, idx, 4'b0000};
            t.colour = colour;
            t.flip_x = fx;
            t.flip_y = fy;
            t.pos_x = px[10:0];
            t.pos_y = row_y[9:0];
            t.last = (j == count - 1);
            expected_tiles.push_back(t);
         end
      endfunction

      function void match(string field, logic [10:0] want, logic [10:0] got);
         if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_tile(tile_t got);
         tile_t want;
         if (expected_tiles.size() == 0) begin
            $error("tile beat with nothing expected, tile_code 'h%0h", got.code);
            errors++;
            return;
         end
         want = expected_tiles.pop_front();
         match("tile_code", 11'(want.code), 11'(got.code));
         match("tile_colour", 11'(want.colour), 11'(got.colour));
         match("flip_x", 11'(want.flip_x), 11'(got.flip_x));
         match("flip_y", 11'(want.flip_y), 11'(got.flip_y));
         match("pos_x", want.pos_x, got.pos_x);
         match("pos_y", 11'(want.pos_y), 11'(got.pos_y));
         match("last_tile", 11'(want.last), 11'(got.last));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and DUT
   // -------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_attr_flags = '0;
   logic [7:0]             req_y_byte = '0;
   logic [7:0]             req_code_byte = '0;
   logic [7:0]             req_x_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [9:0]             rsp_tile_code;
   logic [4:0]             rsp_tile_colour;
   logic                   rsp_flip_x;
   logic                   rsp_flip_y;
   logic signed [10:0]     rsp_pos_x;
   logic signed [9:0]      rsp_pos_y;
   logic                   rsp_last_tile;

   tile_scoreboard sb;
   bit calm = 1'b0;   // set during the stretch with no stalls on either side
   int cycles = 0;

   sprite_attribute_tile_expander_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Stall the result side at random, except in the calm stretch
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 18);
   end

   // Check every tile beat taken at this edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_tile('{rsp_tile_code, rsp_tile_colour, rsp_flip_x, rsp_flip_y,
                         rsp_pos_x, rsp_pos_y, rsp_last_tile});
   end

   // -------------------------------------------------------------------------
   // Driver tasks; each is entered and left just after a rising edge
   // -------------------------------------------------------------------------

   // Offer one entry beat and hold it until accepted, then predict its tiles
   task automatic send_entry(input logic [31:0] entry);
      req_valid <= 1'b1;
      req_attr_flags <= entry[31:24];
      req_y_byte <= entry[23:16];
      req_code_byte <= entry[15:8];
      req_x_byte <= entry[7:0];
      do @(posedge clock); while (!req_ready);
      sb.expand_entry(entry[31:24], entry[23:16], entry[15:8], entry[7:0]);
   endtask

   // Drop valid now and then, outside the calm stretch
   task automatic idle_gap();
      if (!calm && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Hold off the sender until every expected tile beat has come out
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Drain, then give the block its pipeline latency to finish empty entries
   task automatic settle();
      drain();
      repeat (8) @(posedge clock);
   endtask

   // Write both registers and the spare index on back-to-back cycles
   task automatic program_regs(input logic cocktail, input logic [1:0] bank);
      logic [CSR_DATA_W-1:0] data;
      csr_we <= 1'b1;
      data = {1'($urandom_range(0, 1)), cocktail};
      csr_index <= CSR_COCKTAIL;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(CSR_COCKTAIL, data);
      csr_index <= CSR_BANK;
      csr_wdata <= bank;
      @(posedge clock);
      sb.write_reg(CSR_BANK, bank);
      data = CSR_DATA_W'($urandom);
      csr_index <= CSR_SPARE;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(CSR_SPARE, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_entry(DIRECTED[i]);
         idle_gap();
      end
   endtask

   // Mostly random bytes, with the extremes mixed in
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   // Build a random entry; the unused size is kept rare, bank triggers common
   function automatic logic [31:0] random_entry();
      logic [7:0] flags;
      logic [7:0] code;
      flags = 8'($urandom);
      code = pick_byte();
      if (flags[4:3] == SIZE_NONE && $urandom_range(0, 9) != 0)
         flags[4:3] = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
         flags[5] = 1'b1;
         code[3] = 1'b1;
      end
      return {flags, pick_byte(), code, pick_byte()};
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic phase_cocktail [PHASES];
      logic [1:0] phase_bank [PHASES];
      logic [31:0] entry;
      int counted;
      phase_cocktail = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      phase_bank = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3};
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed set at reset settings, then mirrored with another bank
      run_directed();
      settle();
      program_regs(1'b1, 2'd1);
      run_directed();
      settle();

      // Random phases, one register setting each
      for (int p = 0; p < PHASES; p++) begin
         program_regs(phase_cocktail[p], phase_bank[p]);
         calm = (p == 2);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            entry = random_entry();
            send_entry(entry);
            if (entry[28:27] != SIZE_NONE)
               counted++;
            // Halfway through one phase, wait for the output to run dry
            if (p == 4 && counted == ITEMS_PER_PHASE / 2 && entry[28:27] != SIZE_NONE)
               drain();
            else
               idle_gap();
         end
         calm = 1'b0;
         settle();
      end

      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/satx_pkg.sv
sv/satx_decode.sv
sv/sprite_attribute_tile_expander_core.sv
bench/tb_sprite_attribute_tile_expander_core.sv
